// ----- rtl/spq_pkg.sv -----
// Package: shared constants, codes and controller/datapath types for the priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned ENTRY_W      = DATA_W + PRIO_W;
  localparam int unsigned OCC_W        = 4;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [OCC_W-1:0]  occ_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_REM_HEAD,
    ST_REM_SHIFT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    ins_shift;
    logic    ins_place;
    logic    rem_head;
    logic    rem_shift;
    logic    rem_done;
    logic    out_load;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ins_lower;
    logic rem_more;
  } stat_t;

endpackage

// ----- rtl/spq_if.sv -----
// Interfaces: request and result channels of the priority queue.
interface spq_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  spq_pkg::data_t    item_data;
  spq_pkg::prio_t    item_priority;

  modport source (output valid, output req_type, output item_data, output item_priority,
                  input ready);
  modport sink   (input valid, input req_type, input item_data, input item_priority,
                  output ready);
endinterface

interface spq_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  spq_pkg::data_t    out_data;
  spq_pkg::prio_t    out_priority;
  spq_pkg::occ_t     occupancy;

  modport source (output valid, output status, output out_data, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_data, input out_priority,
                  input occupancy, output ready);
endinterface

// ----- rtl/sorted_priority_queue_core.sv -----
// Top level: sorted priority queue, one result per request.
// Insert: each stored entry of lower priority than the new item is moved one slot a cycle
// through the single-port-read, single-port-write memory, then the new item is placed.
// Remove: head read, the rest shifted up one slot; full insert or empty remove: no walk.
// One request at a time; a new request is taken once the previous result is registered.
// Reset clears the entry count and control; entry memory contents are not reset.
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .req_type_i  (in_i.req_type),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (in_i.req_type),
    .item_data_i     (in_i.item_data),
    .item_priority_i (in_i.item_priority),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (out_o.status),
    .out_data_o      (out_o.out_data),
    .out_priority_o  (out_o.out_priority),
    .occupancy_o     (out_o.occupancy)
  );

endmodule

// ----- rtl/spq_datapath.sv -----
// Datapath: entry memory, count, walk pointer, request and result registers.
module spq_datapath #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_type_i,
  input  spq_pkg::data_t  item_data_i,
  input  spq_pkg::prio_t  item_priority_i,
  input  spq_pkg::cmd_t   cmd_i,
  output spq_pkg::stat_t  stat_o,
  output logic [1:0]      status_o,
  output spq_pkg::data_t  out_data_o,
  output spq_pkg::prio_t  out_priority_o,
  output spq_pkg::occ_t   occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rdata_q;
  logic [IdxW-1:0]    rd_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] wr_data;

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  data_t           data_q, head_data_q;
  prio_t           prio_q, head_prio_q;
  logic [1:0]      status_q;
  data_t           odata_q;
  prio_t           oprio_q;
  occ_t            occ_q;

  always_comb begin
    rd_addr = ptr_q;
    if (cmd_i.load) begin
      rd_addr = (req_type_i == REQ_REMOVE) ? '0 : IdxW'(count_q - CntW'(1));
    end else if (cmd_i.ins_shift) begin
      rd_addr = ptr_q - IdxW'(2);
    end else if (cmd_i.rem_head) begin
      rd_addr = IdxW'(1);
    end else if (cmd_i.rem_shift) begin
      rd_addr = ptr_q + IdxW'(2);
    end
  end

  assign mem_we  = cmd_i.ins_shift | cmd_i.ins_place | cmd_i.rem_shift;
  assign wr_data = cmd_i.ins_place ? {prio_q, data_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    if (cmd_i.load) begin
      ptr_d = (req_type_i == REQ_REMOVE) ? '0 : IdxW'(count_q);
    end else if (cmd_i.ins_shift) begin
      ptr_d = ptr_q - IdxW'(1);
    end else if (cmd_i.rem_shift) begin
      ptr_d = ptr_q + IdxW'(1);
    end
    if (cmd_i.ins_place) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.rem_done) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q      <= item_data_i;
      prio_q      <= item_priority_i;
      head_data_q <= '0;
      head_prio_q <= '0;
    end else if (cmd_i.rem_head) begin
      head_data_q <= rdata_q[DATA_W-1:0];
      head_prio_q <= rdata_q[ENTRY_W-1:DATA_W];
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.status;
      odata_q  <= head_data_q;
      oprio_q  <= head_prio_q;
      occ_q    <= OCC_W'(count_q);
    end
  end

  assign stat_o.full      = (count_q == CntW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.ins_lower = (ptr_q != '0) && (rdata_q[ENTRY_W-1:DATA_W] < prio_q);
  assign stat_o.rem_more  = ((CntW'(ptr_q) + CntW'(1)) < count_q);

  assign status_o       = status_q;
  assign out_data_o     = odata_q;
  assign out_priority_o = oprio_q;
  assign occupancy_o    = occ_q;

endmodule

// ----- rtl/spq_ctrl.sv -----
// Controller: sequences insert walks, remove shifts and result handoff.
module spq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o
);
  import spq_pkg::*;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_OK;
          if (req_type_i == REQ_INSERT) begin
            if (stat_i.full) begin
              status_d = STATUS_FULL;
              state_d  = ST_RESULT;
            end else begin
              state_d = ST_INS_CMP;
            end
          end else if (stat_i.empty) begin
            status_d = STATUS_EMPTY;
            state_d  = ST_RESULT;
          end else begin
            state_d = ST_REM_HEAD;
          end
        end
      end
      ST_INS_CMP: begin
        if (!stat_i.ins_lower) state_d = ST_RESULT;
      end
      ST_REM_HEAD:  state_d = ST_REM_SHIFT;
      ST_REM_SHIFT: begin
        if (!stat_i.rem_more) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      ST_IDLE:      cmd_o.load = accept;
      ST_INS_CMP: begin
        cmd_o.ins_shift = stat_i.ins_lower;
        cmd_o.ins_place = !stat_i.ins_lower;
      end
      ST_REM_HEAD:  cmd_o.rem_head = 1'b1;
      ST_REM_SHIFT: begin
        cmd_o.rem_shift = stat_i.rem_more;
        cmd_o.rem_done  = !stat_i.rem_more;
      end
      ST_RESULT:    cmd_o.out_load = out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- tb/sorted_priority_queue_core_tb.sv -----
// Testbench: random and directed requests against a cycle-free priority queue predictor.
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = CAPACITY_DEF;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    req_type_e req;
    data_t     data;
    prio_t     prio;
  } request_t;

  typedef struct {
    status_e status;
    data_t   data;
    prio_t   prio;
    occ_t    occ;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic  drv_valid = 1'b0;
  logic  drv_req = 1'b0;
  data_t drv_data = '0;
  prio_t drv_prio = '0;
  logic  drv_ready = 1'b0;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  assign req_if.valid         = drv_valid;
  assign req_if.req_type      = drv_req;
  assign req_if.item_data     = drv_data;
  assign req_if.item_priority = drv_prio;
  assign rsp_if.ready         = drv_ready;

  sorted_priority_queue_core #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  request_t pending_reqs[$];
  result_t  expected_rsps[$];

  data_t q_data[QUEUE_DEPTH];
  prio_t q_prio[QUEUE_DEPTH];
  int    q_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int offered_cnt = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int mismatches = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_full = 0;
  int n_empty = 0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 20)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic result_t serve_request(request_t r);
    result_t res;
    int k;
    res.status = STATUS_OK;
    res.data = '0;
    res.prio = '0;
    if (r.req == REQ_INSERT) begin
      n_insert++;
      if (q_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
        n_full++;
      end else begin
        k = q_count;
        while (k > 0 && q_prio[k-1] < r.prio) begin
          q_data[k] = q_data[k-1];
          q_prio[k] = q_prio[k-1];
          k--;
        end
        q_data[k] = r.data;
        q_prio[k] = r.prio;
        q_count++;
      end
    end else begin
      n_remove++;
      if (q_count == 0) begin
        res.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        res.data = q_data[0];
        res.prio = q_prio[0];
        for (k = 1; k < q_count; k++) begin
          q_data[k-1] = q_data[k];
          q_prio[k-1] = q_prio[k];
        end
        q_count--;
      end
    end
    res.occ = occ_t'(q_count);
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n) begin
      if (!(drv_valid && accepted_cnt != offered_cnt)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          drv_valid <= 1'b1;
          drv_req   <= nxt.req;
          drv_data  <= nxt.data;
          drv_prio  <= nxt.prio;
          offered_cnt <= offered_cnt + 1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst_n)
      drv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    result_t  want;
    request_t got_req;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", rsp_if.status, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.out_data !== want.data)
            report_mismatch("out_data", rsp_if.out_data, want.data);
          if (rsp_if.out_priority !== want.prio)
            report_mismatch("out_priority", rsp_if.out_priority, want.prio);
          if (rsp_if.occupancy !== want.occ)
            report_mismatch("occupancy", rsp_if.occupancy, want.occ);
        end
        results_seen++;
      end
      if (req_if.valid && req_if.ready) begin
        got_req.req  = req_type_e'(req_if.req_type);
        got_req.data = req_if.item_data;
        got_req.prio = req_if.item_priority;
        expected_rsps.push_back(serve_request(got_req));
        accepted_cnt++;
      end
    end
  end

  task automatic add_req(req_type_e req, data_t data, prio_t prio);
    request_t r;
    r.req = req;
    r.data = data;
    r.prio = prio;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    int ins_pct;
    prio_t p;
    ins_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(3))
          0: ins_pct = 25;
          1: ins_pct = 50;
          2: ins_pct = 75;
          default: ins_pct = 90;
        endcase
      end
      case ($urandom_range(3))
        0: p = prio_t'($urandom_range(3));
        1: p = prio_t'(255 - $urandom_range(1));
        default: p = prio_t'($urandom_range(255));
      endcase
      add_req(($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE,
              data_t'($urandom_range(65535)), p);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || accepted_cnt != offered_cnt ||
           expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty remove, extremes, ties at low, middle and top priority, fill, refused insert, drain
    add_req(REQ_REMOVE, 16'h0000, 8'h00);
    add_req(REQ_INSERT, 16'hFFFF, 8'h00);
    add_req(REQ_INSERT, 16'h0000, 8'hFF);
    add_req(REQ_INSERT, 16'h1234, 8'h80);
    add_req(REQ_INSERT, 16'h5555, 8'h80);
    add_req(REQ_INSERT, 16'hAAAA, 8'h80);
    add_req(REQ_INSERT, 16'h5A5A, 8'h00);
    add_req(REQ_INSERT, 16'hFFFF, 8'hFF);
    add_req(REQ_INSERT, 16'h0001, 8'h01);
    add_req(REQ_INSERT, 16'h0002, 8'hC8);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      add_req(REQ_REMOVE, 16'hFFFF, 8'hFF);
    add_req(REQ_INSERT, 16'h0003, 8'h07);
    add_req(REQ_REMOVE, 16'h0000, 8'h00);
    run_phase(0, 0, 0);

    run_phase(0, 0, 330);
    run_phase(46, 0, 330);
    run_phase(0, 46, 330);
    run_phase(11, 11, 330);

    // receiver holds off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_trig++;
    add_random(310);
    wait_drained();

    repeat (30) @(posedge clk);
    $display("Ran %0d requests in %0d results: %0d inserts (%0d refused full), %0d removes",
             accepted_cnt, results_seen, n_insert, n_full, n_remove);
    $display("  (%0d on an empty queue), under mixed sender gaps and receiver stalls",
             n_empty);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sorted_priority_queue_core.f -----
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
